FILE: sv/plm_pkg.sv
package plm_pkg;

  localparam int PAGE_W = 10;
  localparam int PAGES  = 1 << PAGE_W;
  localparam int LINK_W = PAGE_W + 1;
  localparam int LISTS  = 4;
  localparam int LIST_IDX_W = $clog2(LISTS);

  typedef logic [PAGE_W-1:0]     page_t;
  typedef logic [LINK_W-1:0]     link_t;
  typedef logic [LINK_W-1:0]     count_t;
  typedef logic [2:0]            list_id_t;
  typedef logic [LIST_IDX_W-1:0] list_idx_t;

  localparam link_t NIL = LINK_W'(PAGES);

  localparam list_id_t LIST_NONE     = 3'd0;
  localparam list_id_t LIST_FREE     = 3'd1;
  localparam list_id_t LIST_ACTIVE   = 3'd2;
  localparam list_id_t LIST_INACTIVE = 3'd3;
  localparam list_id_t LIST_DIRTY    = 3'd4;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_POP  = 2'd2,
    CMD_BAD  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_MISUSE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_UNL2,
    S_CLR,
    S_LINK1,
    S_LINK2,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t     command;
    page_t    page;
    list_id_t list;
    logic     at_front;
  } req_t;

  typedef struct packed {
    status_t  status;
    page_t    page_out;
    logic     page_valid;
    list_id_t old_list;
    count_t   tgt_count;
  } rsp_t;

  typedef struct packed {
    list_id_t memb;
    link_t    next_link;
    link_t    prev_link;
  } entry_t;

  typedef struct packed {
    page_t  raddr;
    logic   wr_memb;
    logic   wr_next;
    logic   wr_prev;
    page_t  waddr;
    entry_t wdata;
  } mem_req_t;

  function automatic list_idx_t list_slot(input list_id_t id);
    list_idx_t idx;
    idx = LIST_IDX_W'(id - 3'd1);
    return idx;
  endfunction

endpackage

FILE: sv/page_list_manager.sv
// sequence: an unknown command or a remove-head that fails goes from S_IDLE to S_DONE; a
//   refused add or move, or a move of an unlisted page to no list, passes S_READ and S_EVAL;
//   linking adds S_LINK1 and S_LINK2, unlinking adds S_UNL2 (then S_CLR if nothing relinks)
// requests: one at a time; the page memory holds membership and both links, with a read and
//   a write port, and takes one neighbor update per cycle
// reset: synchronous; a sweep clears all 1024 entries of the page memory, req_ready stays low
module page_list_manager
  import plm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  mem_req_t mreq;
  entry_t   rdata;
  logic     rsp_load;
  rsp_t     result;
  logic     out_free;

  assign out_free = !rsp_valid || rsp_ready;

  plm_page_mem u_mem (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

  plm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_free  (out_free),
    .rsp_load  (rsp_load),
    .result    (result),
    .mreq      (mreq),
    .rdata     (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= result;
    end
  end

endmodule

FILE: sv/plm_page_mem.sv
module plm_page_mem
  import plm_pkg::*;
(
  input  logic     clk,
  input  mem_req_t mreq,
  output entry_t   rdata
);

  entry_t mem [PAGES];

  always_ff @(posedge clk) begin
    if (mreq.wr_memb) begin
      mem[mreq.waddr].memb <= mreq.wdata.memb;
    end
    if (mreq.wr_next) begin
      mem[mreq.waddr].next_link <= mreq.wdata.next_link;
    end
    if (mreq.wr_prev) begin
      mem[mreq.waddr].prev_link <= mreq.wdata.prev_link;
    end
    rdata <= mem[mreq.raddr];
  end

endmodule

FILE: sv/plm_seq.sv
module plm_seq
  import plm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  req_t     req,
  input  logic     out_free,
  output logic     rsp_load,
  output rsp_t     result,
  output mem_req_t mreq,
  input  entry_t   rdata
);

  state_t    state, state_next;
  page_t     init_cnt, init_cnt_next;
  cmd_t      cmd, cmd_next;
  page_t     pg, pg_next;
  list_id_t  lst, lst_next;
  logic      front, front_next;
  status_t   status, status_next;
  page_t     pout, pout_next;
  logic      pvalid, pvalid_next;
  list_id_t  old, old_next;
  link_t     nx, nx_next;
  link_t     pr, pr_next;
  list_idx_t um, um_next;
  link_t     head [LISTS];
  link_t     head_next [LISTS];
  link_t     tail [LISTS];
  link_t     tail_next [LISTS];
  count_t    size [LISTS];
  count_t    size_next [LISTS];

  list_idx_t m;
  list_idx_t m_in;
  logic      real_in;
  logic      real_lst;
  logic      misuse;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_cnt <= '0;
      for (int i = 0; i < LISTS; i++) begin
        head[i] <= NIL;
        tail[i] <= NIL;
        size[i] <= '0;
      end
    end else begin
      state    <= state_next;
      init_cnt <= init_cnt_next;
      for (int i = 0; i < LISTS; i++) begin
        head[i] <= head_next[i];
        tail[i] <= tail_next[i];
        size[i] <= size_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    pg     <= pg_next;
    lst    <= lst_next;
    front  <= front_next;
    status <= status_next;
    pout   <= pout_next;
    pvalid <= pvalid_next;
    old    <= old_next;
    nx     <= nx_next;
    pr     <= pr_next;
    um     <= um_next;
  end

  always_comb begin
    m        = list_slot(lst);
    m_in     = list_slot(req.list);
    real_in  = req.list inside {[LIST_FREE:LIST_DIRTY]};
    real_lst = lst inside {[LIST_FREE:LIST_DIRTY]};
    misuse   = (lst > LIST_DIRTY) ||
               ((cmd == CMD_ADD) && ((lst == LIST_NONE) || (rdata.memb != LIST_NONE)));

    state_next    = state;
    init_cnt_next = init_cnt;
    cmd_next      = cmd;
    pg_next       = pg;
    lst_next      = lst;
    front_next    = front;
    status_next   = status;
    pout_next     = pout;
    pvalid_next   = pvalid;
    old_next      = old;
    nx_next       = nx;
    pr_next       = pr;
    um_next       = um;
    for (int i = 0; i < LISTS; i++) begin
      head_next[i] = head[i];
      tail_next[i] = tail[i];
      size_next[i] = size[i];
    end

    req_ready  = 1'b0;
    rsp_load   = 1'b0;
    result     = '0;
    mreq       = '0;
    mreq.raddr = pg;

    case (state)
      S_INIT: begin
        mreq.wr_memb = 1'b1;
        mreq.wr_next = 1'b1;
        mreq.wr_prev = 1'b1;
        mreq.waddr   = init_cnt;
        mreq.wdata   = '{memb: LIST_NONE, next_link: NIL, prev_link: NIL};
        init_cnt_next = init_cnt + 1'b1;
        if (init_cnt == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd_next    = req.command;
          lst_next    = req.list;
          front_next  = req.at_front;
          status_next = ST_OK;
          old_next    = LIST_NONE;
          case (req.command)
            CMD_ADD, CMD_MOVE: begin
              pg_next     = req.page;
              pout_next   = req.page;
              pvalid_next = 1'b1;
              state_next  = S_READ;
            end
            CMD_POP: begin
              pout_next   = '0;
              pvalid_next = 1'b0;
              if (!real_in) begin
                status_next = ST_MISUSE;
                state_next  = S_DONE;
              end else if (head[m_in] == NIL) begin
                status_next = ST_EMPTY;
                state_next  = S_DONE;
              end else begin
                pg_next    = head[m_in][PAGE_W-1:0];
                state_next = S_READ;
              end
            end
            default: begin
              status_next = ST_MISUSE;
              pout_next   = '0;
              pvalid_next = 1'b0;
              state_next  = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        nx_next  = rdata.next_link;
        pr_next  = rdata.prev_link;
        um_next  = list_slot(rdata.memb);
        old_next = rdata.memb;
        if (cmd == CMD_POP) begin
          pout_next   = pg;
          pvalid_next = 1'b1;
        end
        if ((cmd != CMD_POP) && misuse) begin
          status_next = ST_MISUSE;
          state_next  = S_DONE;
        end else if (rdata.memb != LIST_NONE) begin
          // first half of unlink: predecessor forward link or list head
          if (rdata.prev_link != NIL) begin
            mreq.wr_next         = 1'b1;
            mreq.waddr           = rdata.prev_link[PAGE_W-1:0];
            mreq.wdata.next_link = rdata.next_link;
          end else begin
            head_next[list_slot(rdata.memb)] = rdata.next_link;
          end
          state_next = S_UNL2;
        end else if (lst != LIST_NONE) begin
          state_next = S_LINK1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_UNL2: begin
        if (nx != NIL) begin
          mreq.wr_prev         = 1'b1;
          mreq.waddr           = nx[PAGE_W-1:0];
          mreq.wdata.prev_link = pr;
        end else begin
          tail_next[um] = pr;
        end
        if (size[um] != '0) begin
          size_next[um] = size[um] - 1'b1;
        end
        if ((cmd != CMD_POP) && (lst != LIST_NONE)) begin
          state_next = S_LINK1;
        end else begin
          state_next = S_CLR;
        end
      end
      S_CLR: begin
        mreq.wr_memb    = 1'b1;
        mreq.waddr      = pg;
        mreq.wdata.memb = LIST_NONE;
        state_next      = S_DONE;
      end
      S_LINK1: begin
        mreq.wr_memb = 1'b1;
        mreq.wr_next = 1'b1;
        mreq.wr_prev = 1'b1;
        mreq.waddr   = pg;
        if ((cmd == CMD_ADD) && front) begin
          mreq.wdata = '{memb: lst, next_link: head[m], prev_link: NIL};
        end else begin
          mreq.wdata = '{memb: lst, next_link: NIL, prev_link: tail[m]};
        end
        state_next = S_LINK2;
      end
      S_LINK2: begin
        if ((cmd == CMD_ADD) && front) begin
          if (head[m] != NIL) begin
            mreq.wr_prev         = 1'b1;
            mreq.waddr           = head[m][PAGE_W-1:0];
            mreq.wdata.prev_link = {1'b0, pg};
          end else begin
            tail_next[m] = {1'b0, pg};
          end
          head_next[m] = {1'b0, pg};
        end else begin
          if (tail[m] != NIL) begin
            mreq.wr_next         = 1'b1;
            mreq.waddr           = tail[m][PAGE_W-1:0];
            mreq.wdata.next_link = {1'b0, pg};
          end else begin
            head_next[m] = {1'b0, pg};
          end
          tail_next[m] = {1'b0, pg};
        end
        size_next[m] = size[m] + 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        result.status     = status;
        result.page_out   = pout;
        result.page_valid = pvalid;
        result.old_list   = old;
        if (real_lst && ((cmd == CMD_ADD) || (cmd == CMD_MOVE) ||
                         ((cmd == CMD_POP) && (status == ST_OK)))) begin
          result.tgt_count = size[m];
        end
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: test/page_list_manager_tb.sv
`timescale 1ns / 1ps

module page_list_manager_tb;
  import plm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_ITEMS  = 60;
  localparam int TAIL_CYCLES  = 16;
  localparam int POOL_TOP     = 47;

  class page_list_tracker;
    list_id_t memb [PAGES];
    link_t    fwd  [PAGES];
    link_t    bwd  [PAGES];
    link_t    head [LISTS];
    link_t    tail [LISTS];
    count_t   count [LISTS];
    rsp_t     awaited [$];
    int errors;
    int checked;
    int n_add, n_move, n_pop, n_bad;
    int n_ok, n_empty, n_misuse;

    function new();
      for (int i = 0; i < PAGES; i++) begin
        memb[i] = LIST_NONE;
        fwd[i]  = NIL;
        bwd[i]  = NIL;
      end
      for (int i = 0; i < LISTS; i++) begin
        head[i]  = NIL;
        tail[i]  = NIL;
        count[i] = '0;
      end
    endfunction

    function void detach(page_t p);
      list_idx_t m;
      link_t pr;
      link_t nx;
      m  = list_idx_t'(memb[p] - 3'd1);
      pr = bwd[p];
      nx = fwd[p];
      if (pr < PAGES) fwd[pr[PAGE_W-1:0]] = nx;
      else head[m] = nx;
      if (nx < PAGES) bwd[nx[PAGE_W-1:0]] = pr;
      else tail[m] = pr;
      if (count[m] > 0) count[m] = count[m] - 1'b1;
      memb[p] = LIST_NONE;
    endfunction

    function void attach(page_t p, list_id_t l, bit front);
      list_idx_t m;
      link_t h;
      link_t t;
      m = list_idx_t'(l - 3'd1);
      if (front) begin
        h = head[m];
        bwd[p] = NIL;
        fwd[p] = h;
        if (h < PAGES) bwd[h[PAGE_W-1:0]] = link_t'(p);
        else tail[m] = link_t'(p);
        head[m] = link_t'(p);
      end else begin
        t = tail[m];
        fwd[p] = NIL;
        bwd[p] = t;
        if (t < PAGES) fwd[t[PAGE_W-1:0]] = link_t'(p);
        else head[m] = link_t'(p);
        tail[m] = link_t'(p);
      end
      count[m] = count[m] + 1'b1;
      memb[p] = l;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      list_idx_t m;
      link_t h;
      bit real_list;
      e = '0;
      e.status = ST_OK;
      real_list = r.list != LIST_NONE && r.list <= LIST_DIRTY;
      m = list_idx_t'(r.list - 3'd1);
      case (r.command)
        CMD_ADD, CMD_MOVE: begin
          if (r.command == CMD_ADD) n_add++;
          else n_move++;
          e.page_out   = r.page;
          e.page_valid = 1'b1;
          e.old_list   = memb[r.page];
          if (r.list > LIST_DIRTY ||
              (r.command == CMD_ADD && (r.list == LIST_NONE || e.old_list != LIST_NONE))) begin
            e.status = ST_MISUSE;
          end else begin
            if (e.old_list != LIST_NONE) detach(r.page);
            if (r.list != LIST_NONE) attach(r.page, r.list, r.command == CMD_ADD && r.at_front);
          end
          if (real_list) e.tgt_count = count[m];
        end
        CMD_POP: begin
          n_pop++;
          if (!real_list) begin
            e.status = ST_MISUSE;
          end else begin
            h = head[m];
            if (h >= PAGES) begin
              e.status = ST_EMPTY;
            end else begin
              detach(h[PAGE_W-1:0]);
              e.page_out   = h[PAGE_W-1:0];
              e.page_valid = 1'b1;
              e.old_list   = r.list;
              e.tgt_count  = count[m];
            end
          end
        end
        default: begin
          n_bad++;
          e.status = ST_MISUSE;
        end
      endcase
      awaited.push_back(e);
    endfunction

    task report(string what, int got_v, int want_v);
      if (errors < 20)
        $display("mismatch at response %0d: %s got %0d want %0d", checked, what, got_v, want_v);
      errors++;
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        report("response with no request outstanding, page_out", got.page_out, 0);
        return;
      end
      want = awaited.pop_front();
      checked++;
      case (want.status)
        ST_OK:    n_ok++;
        ST_EMPTY: n_empty++;
        default:  n_misuse++;
      endcase
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.page_out !== want.page_out) report("page_out", got.page_out, want.page_out);
      if (got.page_valid !== want.page_valid)
        report("page_valid", got.page_valid, want.page_valid);
      if (got.old_list !== want.old_list) report("old_list", got.old_list, want.old_list);
      if (got.tgt_count !== want.tgt_count)
        report("tgt_count", got.tgt_count, want.tgt_count);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  bit   quiet;
  int   cycle_count;

  page_list_tracker tracker = new();

  always #4 clk = ~clk;

  page_list_manager dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  function automatic req_t make_req(cmd_t c, int p, list_id_t l, bit f);
    req_t r;
    r.command  = c;
    r.page     = page_t'(p);
    r.list     = l;
    r.at_front = f;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int roll;
    page_t p;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 7) == 0) p = page_t'($urandom);
    else p = page_t'($urandom_range(0, POOL_TOP));
    r.page     = p;
    r.at_front = 1'($urandom_range(0, 1));
    if (roll < 8) begin
      r.command = cmd_t'($urandom_range(0, 3));
      r.list    = list_id_t'($urandom_range(0, 7));
    end else if (roll < 30) begin
      r.command = CMD_POP;
      r.list    = list_id_t'($urandom_range(LIST_FREE, LIST_DIRTY));
    end else if (tracker.memb[p] == LIST_NONE || roll < 34) begin
      r.command = CMD_ADD;
      r.list    = list_id_t'($urandom_range(LIST_FREE, LIST_DIRTY));
    end else begin
      r.command = CMD_MOVE;
      if ($urandom_range(0, 9) == 0) r.list = LIST_NONE;
      else r.list = list_id_t'($urandom_range(LIST_FREE, LIST_DIRTY));
    end
    return r;
  endfunction

  task automatic offer_request(input req_t r);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_ready !== 1'b1);
    tracker.note_request(r);
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  // response side with random stall bursts
  initial begin
    int stall_left;
    rsp_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rsp_valid === 1'b1 && rsp_ready === 1'b1) tracker.check_response(rsp);
      if (stall_left > 0 && !quiet) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    quiet     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    offer_request(make_req(CMD_POP,  0,    LIST_FREE,     1'b0));
    offer_request(make_req(CMD_ADD,  0,    LIST_FREE,     1'b0));
    offer_request(make_req(CMD_ADD,  1023, LIST_FREE,     1'b1));
    offer_request(make_req(CMD_ADD,  5,    LIST_FREE,     1'b0));
    offer_request(make_req(CMD_ADD,  0,    LIST_ACTIVE,   1'b0));
    offer_request(make_req(CMD_ADD,  7,    LIST_NONE,     1'b1));
    offer_request(make_req(CMD_ADD,  7,    3'd6,          1'b0));
    offer_request(make_req(CMD_MOVE, 0,    LIST_DIRTY,    1'b1));
    offer_request(make_req(CMD_MOVE, 5,    3'd7,          1'b0));
    offer_request(make_req(CMD_MOVE, 1023, LIST_NONE,     1'b0));
    offer_request(make_req(CMD_MOVE, 1023, LIST_NONE,     1'b1));
    offer_request(make_req(CMD_MOVE, 9,    LIST_INACTIVE, 1'b0));
    offer_request(make_req(CMD_BAD,  1023, 3'd7,          1'b1));
    offer_request(make_req(CMD_POP,  0,    LIST_NONE,     1'b0));
    offer_request(make_req(CMD_POP,  1023, 3'd5,          1'b1));
    offer_request(make_req(CMD_POP,  0,    LIST_FREE,     1'b0));
    offer_request(make_req(CMD_POP,  0,    LIST_FREE,     1'b0));
    offer_request(make_req(CMD_ADD,  2,    LIST_ACTIVE,   1'b1));
    offer_request(make_req(CMD_ADD,  3,    LIST_ACTIVE,   1'b1));
    offer_request(make_req(CMD_POP,  0,    LIST_ACTIVE,   1'b0));
    offer_request(make_req(CMD_MOVE, 2,    LIST_ACTIVE,   1'b0));
    offer_request(make_req(CMD_POP,  0,    LIST_DIRTY,    1'b0));
    offer_request(make_req(CMD_POP,  0,    LIST_INACTIVE, 1'b0));
    hold_until_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
      if (i % 150 == 75) hold_until_drained();
      offer_request(random_request());
    end
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("requests: %0d add, %0d move, %0d remove-head, %0d unknown command",
             tracker.n_add, tracker.n_move, tracker.n_pop, tracker.n_bad);
    $display("responses checked: %0d (%0d ok, %0d empty list, %0d misuse), %0d mismatches",
             tracker.checked, tracker.n_ok, tracker.n_empty, tracker.n_misuse, tracker.errors);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/plm_pkg.sv
sv/plm_page_mem.sv
sv/plm_seq.sv
sv/page_list_manager.sv
test/page_list_manager_tb.sv
